// ===== src/tgccl_pkg.sv =====
// Package for the tile grid collision and line-of-sight block.
// Holds command codes, register indexes, query kinds and the controller state type.
// No dependencies.
package tgccl_pkg;

  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_COLL  = 2'd1;
  localparam logic [1:0] CMD_LOS   = 2'd2;
  localparam logic [1:0] CMD_NOP   = 2'd3;

  localparam logic REG_CELL_SIZE   = 1'b0;
  localparam logic REG_GRID_EXTENT = 1'b1;

  localparam logic KIND_COLL = 1'b0;
  localparam logic KIND_LOS  = 1'b1;

  typedef enum logic [12:0] {
    S_CLEAR  = 13'h0001,
    S_IDLE   = 13'h0002,
    S_LSETUP = 13'h0004,
    S_LDIVX  = 13'h0008,
    S_LDIVY  = 13'h0010,
    S_PSTART = 13'h0020,
    S_PDIVX  = 13'h0040,
    S_PDIVY  = 13'h0080,
    S_PEXC   = 13'h0100,
    S_PSQ    = 13'h0200,
    S_PCELL  = 13'h0400,
    S_PCHK   = 13'h0800,
    S_FIN    = 13'h1000
  } state_t;

endpackage

// ===== src/tgccl_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port.
// Read data is registered. No dependencies.
module tgccl_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 4096
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [$clog2(DEPTH)-1:0]   waddr,
  input  logic [WIDTH-1:0]           wdata,
  input  logic [$clog2(DEPTH)-1:0]   raddr,
  output logic [WIDTH-1:0]           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/tile_grid_circle_collision_los.sv =====
// Tile grid circle collision with DDA line of sight; uses tgccl_pkg and tgccl_ram.
// A collision query runs two 21-step floor divisions (x, y) by cell_size, then
// 5 squares on one multiplier, then tests each cell in a read and a check state.
// Line of sight first runs two DDA divisions (none for a zero vector), then tests
// up to min(max(|dx|,|dy|)+1, MAX_STEPS) points; the shared divider sets the pace.
// Reset: registers return to cell_size 32, grid_extent 64; a clearing pass over all
// 2**(2*clog2(MAX_GRID)) map entries (4096 by default) empties the map, input stalled.
module tile_grid_circle_collision_los #(
  parameter int MAX_GRID  = 64,
  parameter int MAX_STEPS = 4096
) (
  input  logic               clk,
  input  logic               rst,
  // item input
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         command,
  input  logic [5:0]         cell_col,
  input  logic [5:0]         cell_row,
  input  logic               wall_bit,
  input  logic signed [23:0] pos_x,
  input  logic signed [23:0] pos_y,
  input  logic [15:0]        radius,
  input  logic signed [12:0] sight_dx,
  input  logic signed [12:0] sight_dy,
  // result output
  output logic               out_valid,
  input  logic               out_stall,
  output logic               hit,
  output logic               query_kind,
  // configuration write
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_index,
  input  logic [7:0]         cfg_data
);
  import tgccl_pkg::*;

  localparam int GW    = (MAX_GRID > 1) ? $clog2(MAX_GRID) : 1;
  localparam int AW    = 2 * GW;
  localparam int DEPTH = 1 << AW;
  localparam int CW    = $clog2(MAX_STEPS + 1);
  localparam int DVW   = 21;

  state_t state;

  // configuration registers
  logic [7:0] cell_size;
  logic [6:0] grid_extent;
  logic [7:0] cs_eff;
  logic [8:0] ext_eff;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cell_size   <= 8'd32;
      grid_extent <= 7'd64;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_CELL_SIZE:   cell_size   <= cfg_data;
        REG_GRID_EXTENT: grid_extent <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  // treat a zero cell size as one; clamp the extent to the map size
  assign cs_eff  = (cell_size == 8'd0) ? 8'd1 : cell_size;
  assign ext_eff = (9'(grid_extent) > 9'(MAX_GRID)) ? 9'(MAX_GRID) : 9'(grid_extent);

  // query registers
  logic signed [23:0] q_px, q_py;
  logic [15:0]        q_rad;
  logic               q_kind;
  logic signed [12:0] q_dx, q_dy;
  logic [12:0]        steps;
  logic [CW-1:0]      lim, ptcnt;

  // DDA increments and running offsets (magnitudes, Q.8)
  logic [8:0]     inc_qx, inc_qy;
  logic [12:0]    inc_rx, inc_ry;
  logic [DVW-1:0] off_qx, off_qy;
  logic [12:0]    off_rx, off_ry;

  // per-point cell coordinates and in-cell remainders
  logic signed [16:0] nx, ny;
  logic [15:0]        remx, remy;
  logic [15:0]        ex0, ex1, ey0, ey1;
  logic [31:0]        sqx0, sqx1, sqy0, sqy1, r2;
  logic [2:0]         sq_cnt;
  logic [1:0]         cell_k;
  logic               cand;

  // shared restoring divider, one quotient bit per cycle
  logic [DVW-1:0] div_quo;
  logic [12:0]    div_rem, div_dsr;
  logic [4:0]     div_cnt;
  logic [13:0]    div_sh;
  logic           div_ge;
  logic [12:0]    div_rem_step;
  logic           div_done;

  assign div_sh       = {div_rem, div_quo[DVW-1]};
  assign div_ge       = div_sh >= {1'b0, div_dsr};
  assign div_rem_step = div_ge ? 13'(div_sh - {1'b0, div_dsr}) : div_sh[12:0];
  assign div_done     = (div_cnt == 5'(DVW));

  // current sample point: query point plus signed DDA offset
  logic signed [24:0] x_pt, y_pt;
  logic signed [24:0] offx_s, offy_s;
  logic [15:0]        ux, uy;
  logic               negx, negy;

  assign offx_s = q_dx[12] ? -$signed({4'b0, off_qx}) : $signed({4'b0, off_qx});
  assign offy_s = q_dy[12] ? -$signed({4'b0, off_qy}) : $signed({4'b0, off_qy});
  assign x_pt   = $signed({q_px[23], q_px}) + offx_s;
  assign y_pt   = $signed({q_py[23], q_py}) + offy_s;
  // floor(a/b) for negative a is ~((~a)/b)
  assign negx   = x_pt[24];
  assign negy   = y_pt[24];
  assign ux     = negx ? ~x_pt[23:8] : x_pt[23:8];
  assign uy     = negy ? ~y_pt[23:8] : y_pt[23:8];

  // cell coordinates after a division
  logic signed [16:0] n_div;
  logic [7:0]         rf_x, rf_y;
  assign n_div = $signed({1'b0, div_quo[15:0]});
  assign rf_x  = negx ? 8'(cs_eff - 8'd1 - div_rem[7:0]) : div_rem[7:0];
  assign rf_y  = negy ? 8'(cs_eff - 8'd1 - div_rem[7:0]) : div_rem[7:0];

  // DDA setup values
  logic [12:0] ax, ay, steps_c;
  logic [13:0] steps_p1;
  assign ax       = q_dx[12] ? 13'(-q_dx) : 13'(q_dx);
  assign ay       = q_dy[12] ? 13'(-q_dy) : 13'(q_dy);
  assign steps_c  = (ax > ay) ? ax : ay;
  assign steps_p1 = {1'b0, steps_c} + 14'd1;

  // DDA advance
  logic [13:0] rsx, rsy;
  logic        cx, cy;
  assign rsx = {1'b0, off_rx} + {1'b0, inc_rx};
  assign rsy = {1'b0, off_ry} + {1'b0, inc_ry};
  assign cx  = rsx >= {1'b0, steps};
  assign cy  = rsy >= {1'b0, steps};

  // excess per axis
  logic [15:0] half;
  assign half = {1'b0, cs_eff, 7'b0};

  // one shared squarer
  logic [15:0] sq_op;
  logic [31:0] sq_prod;
  always_comb begin
    case (sq_cnt)
      3'd0:    sq_op = ex0;
      3'd1:    sq_op = ex1;
      3'd2:    sq_op = ey0;
      3'd3:    sq_op = ey1;
      default: sq_op = q_rad;
    endcase
  end
  assign sq_prod = sq_op * sq_op;

  // cell test
  logic signed [17:0] cellc, cellr;
  logic               cell_inr, cell_touch;
  logic [32:0]        dist2;
  assign cellc      = $signed({nx[16], nx}) + $signed({17'b0, cell_k[0]});
  assign cellr      = $signed({ny[16], ny}) + $signed({17'b0, cell_k[1]});
  assign cell_inr   = !cellc[17] && !cellr[17]
                      && (cellc[16:0] < 17'(ext_eff)) && (cellr[16:0] < 17'(ext_eff));
  assign dist2      = {1'b0, cell_k[0] ? sqx1 : sqx0} + {1'b0, cell_k[1] ? sqy1 : sqy0};
  assign cell_touch = dist2 <= {1'b0, r2};

  // map memory
  logic          ram_we, ram_rdata;
  logic [AW-1:0] ram_waddr, ram_raddr, clr_addr;
  logic          ram_wdata;
  logic          in_acc, wr_ok;

  assign in_stall  = (state != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign wr_ok     = (9'(cell_col) < 9'(MAX_GRID)) && (9'(cell_row) < 9'(MAX_GRID));
  assign ram_raddr = {GW'(cellc[16:0]), GW'(cellr[16:0])};

  always_comb begin
    if (state == S_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr;
      ram_wdata = 1'b0;
    end else begin
      ram_we    = in_acc && (command == CMD_WRITE) && wr_ok;
      ram_waddr = {GW'(cell_col), GW'(cell_row)};
      ram_wdata = wall_bit;
    end
  end

  tgccl_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // controller and datapath
  logic res_hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      out_valid <= 1'b0;
      div_cnt   <= '0;
    end else begin
      // drop the result once transferred; the finish state loads its own
      if (out_valid && !out_stall && state != S_FIN) begin
        out_valid <= 1'b0;
      end
      // step the divider while it runs
      if (!div_done) begin
        div_quo <= {div_quo[DVW-2:0], div_ge};
        div_rem <= div_rem_step;
        div_cnt <= div_cnt + 5'd1;
      end
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == {AW{1'b1}}) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_acc) begin
            q_px   <= pos_x;
            q_py   <= pos_y;
            // sight points are tested with radius zero
            q_rad  <= (command == CMD_LOS) ? 16'd0 : radius;
            q_dx   <= sight_dx;
            q_dy   <= sight_dy;
            off_qx <= '0;
            off_qy <= '0;
            off_rx <= '0;
            off_ry <= '0;
            ptcnt  <= '0;
            case (command)
              CMD_COLL: begin
                q_kind <= KIND_COLL;
                state  <= S_PSTART;
              end
              CMD_LOS: begin
                q_kind <= KIND_LOS;
                state  <= S_LSETUP;
              end
              default: ;
            endcase
          end
        end
        S_LSETUP: begin
          steps <= steps_c;
          lim   <= (32'(steps_p1) > 32'(MAX_STEPS)) ? CW'(MAX_STEPS) : CW'(steps_p1);
          if (steps_c == 13'd0) begin
            inc_qx <= '0;
            inc_qy <= '0;
            inc_rx <= '0;
            inc_ry <= '0;
            state  <= S_PSTART;
          end else begin
            div_quo <= {ax, 8'b0};
            div_rem <= '0;
            div_dsr <= steps_c;
            div_cnt <= '0;
            state   <= S_LDIVX;
          end
        end
        S_LDIVX: begin
          if (div_done) begin
            inc_qx  <= div_quo[8:0];
            inc_rx  <= div_rem;
            div_quo <= {ay, 8'b0};
            div_rem <= '0;
            div_cnt <= '0;
            state   <= S_LDIVY;
          end
        end
        S_LDIVY: begin
          if (div_done) begin
            inc_qy <= div_quo[8:0];
            inc_ry <= div_rem;
            state  <= S_PSTART;
          end
        end
        S_PSTART: begin
          div_quo <= DVW'(ux);
          div_rem <= '0;
          div_dsr <= {5'b0, cs_eff};
          div_cnt <= '0;
          state   <= S_PDIVX;
        end
        S_PDIVX: begin
          if (div_done) begin
            nx      <= negx ? ~n_div : n_div;
            remx    <= {rf_x, x_pt[7:0]};
            div_quo <= DVW'(uy);
            div_rem <= '0;
            div_cnt <= '0;
            state   <= S_PDIVY;
          end
        end
        S_PDIVY: begin
          if (div_done) begin
            ny    <= negy ? ~n_div : n_div;
            remy  <= {rf_y, y_pt[7:0]};
            state <= S_PEXC;
          end
        end
        S_PEXC: begin
          ex0    <= (remx > half) ? 16'(remx - half) : 16'd0;
          ex1    <= (half > remx) ? 16'(half - remx) : 16'd0;
          ey0    <= (remy > half) ? 16'(remy - half) : 16'd0;
          ey1    <= (half > remy) ? 16'(half - remy) : 16'd0;
          sq_cnt <= '0;
          state  <= S_PSQ;
        end
        S_PSQ: begin
          case (sq_cnt)
            3'd0:    sqx0 <= sq_prod;
            3'd1:    sqx1 <= sq_prod;
            3'd2:    sqy0 <= sq_prod;
            3'd3:    sqy1 <= sq_prod;
            default: r2   <= sq_prod;
          endcase
          sq_cnt <= sq_cnt + 3'd1;
          if (sq_cnt == 3'd4) begin
            cell_k <= '0;
            state  <= S_PCELL;
          end
        end
        S_PCELL: begin
          // map read is issued this cycle; data is back in the check cycle
          cand  <= cell_inr && cell_touch;
          state <= S_PCHK;
        end
        S_PCHK: begin
          if (cand && ram_rdata) begin
            res_hit <= 1'b1;
            state   <= S_FIN;
          end else if (cell_k != 2'd3) begin
            cell_k <= cell_k + 2'd1;
            state  <= S_PCELL;
          end else if (q_kind == KIND_LOS && (ptcnt + 1'b1) != lim) begin
            // advance to the next sample point
            ptcnt  <= ptcnt + 1'b1;
            off_rx <= cx ? 13'(rsx - {1'b0, steps}) : rsx[12:0];
            off_ry <= cy ? 13'(rsy - {1'b0, steps}) : rsy[12:0];
            off_qx <= off_qx + DVW'(inc_qx) + DVW'(cx);
            off_qy <= off_qy + DVW'(inc_qy) + DVW'(cy);
            state  <= S_PSTART;
          end else begin
            res_hit <= 1'b0;
            state   <= S_FIN;
          end
        end
        S_FIN: begin
          // hold until the output register is free
          if (!out_valid || !out_stall) begin
            out_valid  <= 1'b1;
            hit        <= res_hit;
            query_kind <= q_kind;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // checks
  a_clear_after_reset: assert property (@(posedge clk)
    $past(rst) && !rst |-> state == S_CLEAR)
    else $error("map clearing pass did not start after reset");

  a_div_bound: assert property (@(posedge clk) disable iff (rst)
    div_cnt <= 5'(DVW))
    else $error("divider step count overran");

  a_dda_rem: assert property (@(posedge clk) disable iff (rst)
    (state == S_PSTART && q_kind == KIND_LOS && steps != 13'd0)
      |-> (off_rx < steps && off_ry < steps))
    else $error("DDA remainder out of range");

  a_pt_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_PCHK && q_kind == KIND_LOS) |-> ptcnt < lim)
    else $error("line of sight point count beyond limit");

endmodule
